@@ sv/text_display_filter_defines.svh @@
// Assertion macros for the RTL file that carries checks, tdf_back.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef TEXT_DISPLAY_FILTER_DEFINES_SVH
`define TEXT_DISPLAY_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define TDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ sv/tdf_pkg.sv @@
package tdf_pkg;

    // Prefix that goes in front of the final displayed byte.
    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_CARET,
        PRE_META
    } t_prefix;

    // One classified input byte, as handed from the front to the back.
    typedef struct packed {
        logic    num;
        logic    dollar;
        t_prefix prefix;
        logic [7:0] ch;
    } t_desc;

    typedef struct packed {
        logic number_all_lines;
        logic number_nonblank_lines;
        logic squeeze_blank_runs;
        logic show_nonprinting;
        logic show_line_ends;
        logic show_tabs;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_NUMBER_ALL,
        REG_NUMBER_NONBLANK,
        REG_SQUEEZE,
        REG_SHOW_NONPRINTING,
        REG_SHOW_ENDS,
        REG_SHOW_TABS
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_DIGIT,
        PH_TAB,
        PH_DOLLAR,
        PH_META_M,
        PH_META_DASH,
        PH_CARET,
        PH_CHAR
    } t_phase;

    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTL_LIMIT  = 8'h20;
    localparam logic [7:0] CH_META_LOW   = 8'h80;
    localparam logic [7:0] CH_META_LIMIT = 8'hA0;
    localparam logic [7:0] CARET_OFFSET  = 8'h40;

endpackage

@@ sv/tdf_queue.sv @@
module tdf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import tdf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ sv/tdf_front.sv @@
module tdf_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_in_byte,
    input  tdf_pkg::t_cfg                i_cfg,
    output logic                         o_q_push,
    output tdf_pkg::t_desc               o_desc,
    output logic [4*NUMBER_DIGITS-1:0]   o_bcd
);
    import tdf_pkg::*;

    localparam int BCD_W = 4 * NUMBER_DIGITS;

    logic             r_at_line_start;
    logic [1:0]       r_newline_run;
    logic [BCD_W-1:0] r_line_bcd;

    logic             is_nl;
    logic [1:0]       run_new, run_final;
    logic             held, num, dollar, bump, als_final;
    logic [BCD_W-1:0] bcd_inc;
    logic             carry;
    logic [3:0]       digit;

    assign is_nl   = (i_in_byte == CH_NL);
    assign run_new = !is_nl ? 2'd0 : ((r_newline_run == 2'd3) ? 2'd3 : r_newline_run + 2'd1);
    assign held    = i_cfg.squeeze_blank_runs && (run_new == 2'd3);
    assign num     = !held && r_at_line_start &&
                     ((i_cfg.number_nonblank_lines && (run_new == 2'd0)) ||
                      (!i_cfg.number_nonblank_lines && i_cfg.number_all_lines));
    assign dollar  = i_cfg.show_line_ends && (run_new != 2'd0) && !held;
    assign bump    = (run_new != 2'd0) && !held &&
                     (!i_cfg.number_nonblank_lines || (run_new == 2'd1));
    assign run_final = held ? 2'd2 : run_new;

    // The line flag is cleared by a printed number and set again by any line end.
    always_comb begin
        als_final = r_at_line_start;
        if (held) begin
            als_final = 1'b1;
        end else if (num) begin
            als_final = 1'b0;
        end
        if (dollar || bump) begin
            als_final = 1'b1;
        end
    end

    // Saturating decimal increment; carry stays high only across digits at nine.
    always_comb begin
        carry   = 1'b1;
        bcd_inc = r_line_bcd;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            digit = r_line_bcd[4*i +: 4];
            if (carry) begin
                if (digit >= 4'd9) begin
                    bcd_inc[4*i +: 4] = 4'd0;
                end else begin
                    bcd_inc[4*i +: 4] = digit + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_desc.num    = num;
        o_desc.dollar = dollar;
        if (i_cfg.show_tabs && (i_in_byte == CH_TAB)) begin
            o_desc.prefix = PRE_CARET;
            o_desc.ch     = CH_I;
        end else if (i_cfg.show_nonprinting && (i_in_byte >= CH_META_LOW) &&
                     (i_in_byte < CH_META_LIMIT)) begin
            o_desc.prefix = PRE_META;
            o_desc.ch     = i_in_byte - CARET_OFFSET;
        end else if (i_cfg.show_nonprinting && (i_in_byte < CH_CTL_LIMIT) &&
                     (i_in_byte != CH_TAB) && !is_nl) begin
            o_desc.prefix = PRE_CARET;
            o_desc.ch     = i_in_byte + CARET_OFFSET;
        end else if (i_cfg.show_nonprinting && (i_in_byte == CH_DEL)) begin
            o_desc.prefix = PRE_CARET;
            o_desc.ch     = i_in_byte - CARET_OFFSET;
        end else begin
            o_desc.prefix = PRE_NONE;
            o_desc.ch     = i_in_byte;
        end
    end

    assign o_q_push = i_accept && !held;
    assign o_bcd    = r_line_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_newline_run   <= 2'd0;
            r_line_bcd      <= BCD_W'(1);
        end else if (i_accept) begin
            r_at_line_start <= als_final;
            r_newline_run   <= run_final;
            if (bump && !carry) begin
                r_line_bcd <= bcd_inc;
            end
        end
    end

endmodule

@@ sv/tdf_back.sv @@
`include "text_display_filter_defines.svh"

module tdf_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  tdf_pkg::t_desc               i_q_desc,
    input  logic [4*NUMBER_DIGITS-1:0]   i_q_bcd,
    output logic                         o_q_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [7:0]                   o_out_byte,
    output logic                         o_run_last
);
    import tdf_pkg::*;

    localparam int IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

    t_phase           r_phase, n_phase, cur_phase;
    logic [IDX_W-1:0] r_idx, n_idx, cur_idx;
    logic             r_lead, n_lead, cur_lead;
    logic             r_mid, n_mid;
    logic             r_out_valid;
    logic [7:0]       r_out_byte, byte_val;
    logic             r_out_last;
    logic             go, is_space;
    logic [3:0]       digit;

    function automatic t_phase after_dollar(input t_prefix p);
        t_phase ph;
        case (p)
            PRE_META:  ph = PH_META_M;
            PRE_CARET: ph = PH_CARET;
            default:   ph = PH_CHAR;
        endcase
        return ph;
    endfunction

    function automatic t_phase after_tab(input t_desc d);
        return d.dollar ? PH_DOLLAR : after_dollar(d.prefix);
    endfunction

    // A descriptor that has not started yet begins at its first enabled phase.
    assign cur_phase = r_mid ? r_phase : (i_q_desc.num ? PH_DIGIT : after_tab(i_q_desc));
    assign cur_idx   = r_mid ? r_idx : IDX_W'(NUMBER_DIGITS - 1);
    assign cur_lead  = r_mid ? r_lead : 1'b1;
    assign go        = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop   = go && (cur_phase == PH_CHAR);

    always_comb begin
        digit = i_q_bcd[4*cur_idx +: 4];
        if (digit > 4'd9) begin
            digit = 4'd9;
        end
    end
    assign is_space = cur_lead && (digit == 4'd0) && (cur_idx != '0);

    // Next-state logic of the expansion sequencer.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_lead  = r_lead;
        n_mid   = r_mid;
        if (go) begin
            n_mid = 1'b1;
            unique case (cur_phase)
                PH_DIGIT: begin
                    n_lead = is_space;
                    if (cur_idx == '0) begin
                        n_phase = PH_TAB;
                    end else begin
                        n_phase = PH_DIGIT;
                        n_idx   = cur_idx - 1'b1;
                    end
                end
                PH_TAB:       n_phase = after_tab(i_q_desc);
                PH_DOLLAR:    n_phase = after_dollar(i_q_desc.prefix);
                PH_META_M:    n_phase = PH_META_DASH;
                PH_META_DASH: n_phase = PH_CARET;
                PH_CARET:     n_phase = PH_CHAR;
                PH_CHAR:      n_mid   = 1'b0;
                default:      n_mid   = 1'b0;
            endcase
        end
    end

    // Output byte of the current phase.
    always_comb begin
        unique case (cur_phase)
            PH_DIGIT:     byte_val = is_space ? CH_SPACE : (CH_ZERO + {4'd0, digit});
            PH_TAB:       byte_val = CH_TAB;
            PH_DOLLAR:    byte_val = CH_DOLLAR;
            PH_META_M:    byte_val = CH_M;
            PH_META_DASH: byte_val = CH_DASH;
            PH_CARET:     byte_val = CH_CARET;
            PH_CHAR:      byte_val = i_q_desc.ch;
            default:      byte_val = i_q_desc.ch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CHAR;
            r_idx       <= '0;
            r_lead      <= 1'b1;
            r_mid       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_lead  <= n_lead;
            r_mid   <= n_mid;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte <= byte_val;
            r_out_last <= (cur_phase == PH_CHAR);
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

    `TDF_ASSERT_IMPLY(a_mid_keeps_head, r_mid, !i_q_empty)
    `TDF_ASSERT_NEXT(a_char_ends_desc, go && (cur_phase == PH_CHAR), !r_mid)
    `TDF_ASSERT_NEXT(a_pop_marks_last, o_q_pop, r_out_valid && r_out_last)

endmodule

@@ sv/text_display_filter.sv @@
// An accepted byte passes the descriptor queue, and the back registers its first display byte.
// Throughput: one display byte per cycle unless pop stalls, limited by the single sequencer in tdf_back.
// An input byte holds the expansion sequencer until all of its 1 to 11 display bytes are registered.
// Input bytes are taken every cycle while the four-entry descriptor queue has room.
// Reset is synchronous, active low: registers read 0, line counter 1, queue and output empty.
module text_display_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input byte stream, queue style.
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        i_in_byte,
    // Display byte stream, queue style.
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        o_out_byte,
    output logic                              o_run_last,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tdf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tdf_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tdf_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tdf_pkg::*;

    localparam int BCD_W  = 4 * NUMBER_DIGITS;
    localparam int DESC_W = BCD_W + $bits(t_desc);

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             cfg_wr;
    logic             accept;
    logic             q_push, q_full, q_empty, q_pop;
    t_desc            f_desc, q_desc;
    logic [BCD_W-1:0] f_bcd, q_bcd;

    // The register port never waits. The register index comes from the word
    // address, so the low two address bits are ignored.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NUMBER_ALL:       r_cfg.number_all_lines      <= pwdata[0];
                REG_NUMBER_NONBLANK:  r_cfg.number_nonblank_lines <= pwdata[0];
                REG_SQUEEZE:          r_cfg.squeeze_blank_runs    <= pwdata[0];
                REG_SHOW_NONPRINTING: r_cfg.show_nonprinting      <= pwdata[0];
                REG_SHOW_ENDS:        r_cfg.show_line_ends        <= pwdata[0];
                REG_SHOW_TABS:        r_cfg.show_tabs             <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Reads return the single option bit in bit 0; unused addresses read zero.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_NUMBER_ALL:       prdata[0] = r_cfg.number_all_lines;
            REG_NUMBER_NONBLANK:  prdata[0] = r_cfg.number_nonblank_lines;
            REG_SQUEEZE:          prdata[0] = r_cfg.squeeze_blank_runs;
            REG_SHOW_NONPRINTING: prdata[0] = r_cfg.show_nonprinting;
            REG_SHOW_ENDS:        prdata[0] = r_cfg.show_line_ends;
            REG_SHOW_TABS:        prdata[0] = r_cfg.show_tabs;
            default:              prdata    = '0;
        endcase
    end

    // An input transaction completes whenever the descriptor queue has room.
    // The front updates the line state at once, so a squeezed newline simply
    // leaves no descriptor behind and produces no display bytes.
    assign full   = q_full;
    assign accept = push && !q_full;

    tdf_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_cfg     (r_cfg),
        .o_q_push  (q_push),
        .o_desc    (f_desc),
        .o_bcd     (f_bcd)
    );

    // The queue carries each descriptor together with a snapshot of the line
    // number, so the back can print a number while the front moves on.
    tdf_queue #(
        .WIDTH(DESC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_bcd, f_desc}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  ({q_bcd, q_desc})
    );

    // The back walks through digits, tab, dollar sign, M- and caret prefixes and the final
    // byte, one display transaction per cycle into its output register while pop allows.
    tdf_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_desc   (q_desc),
        .i_q_bcd    (q_bcd),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tdf_pkg::*;

    // The instance keeps the default of six digits; the line number model
    // below relies on the same width.
    localparam int DIGITS = 6;

    // Number of consecutive cycles without any accepted transaction, on either
    // side, after which the run is declared hung. The slowest legal stretch is
    // one input byte that expands to eleven display bytes, each one waiting
    // out the longest receiver stall, behind the longest sender gap. A register
    // update adds the settle pause and the bus cycles of six writes. The limit
    // leaves ample margin over all of these.
    localparam int IDLE_LIMIT = 2000;

    // The block registers the first display byte of an accepted input byte
    // after it passes the descriptor queue. A squeezed newline produces nothing
    // and leaves no descriptor behind, since the front absorbs it on acceptance.
    // This pause lets the block settle after the last expected byte has arrived.
    localparam int SETTLE_CYCLES = 16;

    // One expected display byte and its end-of-run marker.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_disp;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  push      = 1'b0;
    logic                  full;
    logic [7:0]            i_in_byte = 8'h00;
    logic                  empty;
    logic                  pop       = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_run_last;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    text_display_filter #(
        .NUMBER_DIGITS(DIGITS)
    ) u_top (
        .*
    );

    // The clock runs with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Our own copy of the display options and of the line state. These are
    // updated when a register write completes and when an input byte is
    // accepted, so they always describe what the block should be doing.
    t_cfg        opts     = '0;
    logic        at_start = 1'b1;
    logic [1:0]  nl_run   = 2'd0;
    logic [23:0] line_bcd = 24'h000001;

    // Display bytes that have been worked out but not yet seen on the outputs.
    t_disp display_q[$];

    int errors          = 0;
    int bytes_sent      = 0;
    int bytes_checked   = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;

    // Idling controls. The sender works in bursts of burst_left transactions
    // and pauses between bursts for a random length bounded by gap_max. The
    // receiver stalls for a random length bounded by stall_max; zero turns its stalls off.
    int burst_left = 0;
    int gap_max    = 0;
    int stall_max  = 0;
    int stall_left = 0;

    // ------------------------------------------------------------------
    // Expected behavior of the display filter.
    // ------------------------------------------------------------------

    function automatic void put_disp(input logic [7:0] ch);
        display_q.push_back({ch, 1'b0});
    endfunction

    // The line number is printed right-justified with leading spaces and is
    // followed by a tab. The lowest digit is always printed, even when zero.
    function automatic void put_line_number();
        logic       lead;
        logic [3:0] d;
        int         i;
        lead = 1'b1;
        for (i = DIGITS - 1; i >= 0; i--) begin
            d = line_bcd[4*i +: 4];
            if (d > 4'd9) begin
                d = 4'd9;
            end
            if (lead && d == 4'd0 && i > 0) begin
                put_disp(CH_SPACE);
            end else begin
                lead = 1'b0;
                put_disp(CH_ZERO + {4'd0, d});
            end
        end
        put_disp(CH_TAB);
    endfunction

    // Decimal increment of the line counter, which sticks at all nines.
    function automatic void advance_line_number();
        logic carry;
        int   i;
        if (line_bcd != 24'h999999) begin
            carry = 1'b1;
            for (i = 0; i < DIGITS; i++) begin
                if (carry) begin
                    if (line_bcd[4*i +: 4] >= 4'd9) begin
                        line_bcd[4*i +: 4] = 4'd0;
                    end else begin
                        line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                        carry = 1'b0;
                    end
                end
            end
        end
    endfunction

    // Works out the display bytes for one accepted input byte and appends
    // them to display_q, marking the final one.
    function automatic void render_byte(input logic [7:0] in_b);
        logic [7:0] c;
        logic       shown;
        logic       held;
        logic       ctl;
        int         first;
        t_disp      tail;
        c     = in_b;
        shown = 1'b1;
        held  = 1'b0;
        first = display_q.size();

        // The newline run count saturates at three.
        if (c == CH_NL) begin
            if (nl_run != 2'd3) begin
                nl_run = nl_run + 2'd1;
            end
        end else begin
            nl_run = 2'd0;
        end

        // A third newline in a row is dropped when squeezing is on. The run
        // count falls back to two so that the following newline is dropped
        // as well, and the line counter does not move.
        if (opts.squeeze_blank_runs && nl_run == 2'd3) begin
            at_start = 1'b1;
            shown    = 1'b0;
            nl_run   = 2'd2;
            held     = 1'b1;
        end else if ((opts.number_nonblank_lines && at_start && nl_run == 2'd0) ||
                     (!opts.number_nonblank_lines && opts.number_all_lines && at_start)) begin
            put_line_number();
            at_start = 1'b0;
        end

        if (opts.show_line_ends && nl_run != 2'd0 && shown) begin
            at_start = 1'b1;
            put_disp(CH_DOLLAR);
        end

        if (opts.show_tabs && c == CH_TAB) begin
            put_disp(CH_CARET);
            put_disp(CH_I);
            shown = 1'b0;
        end

        // Caret notation: low controls and delete get a caret, the high
        // controls get an M-^ prefix, and the byte itself is moved by 64.
        if (opts.show_nonprinting) begin
            ctl = (c < CH_CTL_LIMIT) && nl_run == 2'd0 && c != CH_TAB;
            if (c >= CH_META_LOW && c < CH_META_LIMIT) begin
                put_disp(CH_M);
                put_disp(CH_DASH);
                put_disp(CH_CARET);
            end
            if (ctl || c == CH_DEL) begin
                put_disp(CH_CARET);
            end
            if ((c < CH_CTL_LIMIT || (c >= CH_DEL && c < CH_META_LIMIT)) &&
                nl_run == 2'd0 && c != CH_TAB) begin
                c = (c >= CH_DEL) ? c - CARET_OFFSET : c + CARET_OFFSET;
            end
        end

        // In non-blank mode only the first newline of a run moves the counter.
        if (nl_run != 2'd0 && (!opts.number_nonblank_lines || nl_run == 2'd1) && !held) begin
            at_start = 1'b1;
            advance_line_number();
        end

        if (shown) begin
            put_disp(c);
        end

        if (display_q.size() > first) begin
            tail      = display_q.pop_back();
            tail.last = 1'b1;
            display_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: receiver stalls, checking and the hang watchdog.
    // ------------------------------------------------------------------

    // The receiver pops every cycle unless it is inside a stall. Stalls start
    // at random and last a random number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            pop <= 1'b0;
            stall_left--;
        end else begin
            pop <= 1'b1;
            if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, stall_max);
            end
        end
    end

    // Every accepted display byte is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_disp want;
        if (i_rst_n && pop && !empty) begin
            if (display_q.size() == 0) begin
                errors++;
                $display("%0t ns: display byte %h (last %b) arrived with none expected",
                         $time, o_out_byte, o_run_last);
            end else begin
                want = display_q.pop_front();
                bytes_checked++;
                if (o_out_byte !== want.ch) begin
                    errors++;
                    $display("%0t ns: out_byte expected %h, got %h",
                             $time, want.ch, o_out_byte);
                end
                if (o_run_last !== want.last) begin
                    errors++;
                    $display("%0t ns: run_last expected %b, got %b",
                             $time, want.last, o_run_last);
                end
            end
        end
    end

    // The watchdog ends the run when neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d display bytes still expected",
                     $time, IDLE_LIMIT, display_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side and register port.
    // ------------------------------------------------------------------

    // Sends one input byte and waits for the block to take it. A new burst
    // begins with a random pause, during which push is low.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        render_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    // Stops sending and waits until every expected byte has been seen and
    // the block has had time to finish any byte that displays nothing.
    task automatic drain_and_settle();
        push <= 1'b0;
        burst_left = 0;
        while (display_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: a setup phase, then an access phase that completes
    // on the edge where pready is high. Only bit 0 of the data matters, so
    // the upper bits carry random values. The select is left high so that
    // back-to-back writes do not touch it twice in one step.
    task automatic write_option(input t_reg_idx idx, input logic v);
        logic [CFG_DATA_W-1:0] data;
        data    = $urandom();
        data[0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_NUMBER_ALL:       opts.number_all_lines      = v;
            REG_NUMBER_NONBLANK:  opts.number_nonblank_lines = v;
            REG_SQUEEZE:          opts.squeeze_blank_runs    = v;
            REG_SHOW_NONPRINTING: opts.show_nonprinting      = v;
            REG_SHOW_ENDS:        opts.show_line_ends        = v;
            REG_SHOW_TABS:        opts.show_tabs             = v;
            default: ;
        endcase
    endtask

    // Writes all six option registers while the block is idle.
    task automatic apply_options(input t_cfg c);
        drain_and_settle();
        write_option(REG_NUMBER_ALL, c.number_all_lines);
        write_option(REG_NUMBER_NONBLANK, c.number_nonblank_lines);
        write_option(REG_SQUEEZE, c.squeeze_blank_runs);
        write_option(REG_SHOW_NONPRINTING, c.show_nonprinting);
        write_option(REG_SHOW_ENDS, c.show_line_ends);
        write_option(REG_SHOW_TABS, c.show_tabs);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // Mostly ordinary text with plenty of newlines and tabs, plus some bytes
    // drawn from the whole range.
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            return CH_NL;
        end else if (pick < 28) begin
            return CH_TAB;
        end else if (pick < 42) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(32, 126));
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Straight after reset, with non-blank numbering, squeezing and line
    // ends on. The run count starts from zero, so the first two newlines
    // print and the third and fourth are dropped. The opening newline counts
    // as the first of a run and moves the counter, so the text line that
    // follows is numbered two.
    task automatic test_stream_start_squeeze();
        t_cfg c;
        c = '0;
        c.number_nonblank_lines = 1'b1;
        c.squeeze_blank_runs    = 1'b1;
        c.show_line_ends        = 1'b1;
        gap_max   = 2;
        stall_max = 3;
        apply_options(c);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte("A");
        send_byte(CH_NL);
    endtask

    // Boundary bytes of every class with numbering and all display options
    // on: the control range edges, tab, the printable range edges, delete,
    // the high control range edges and both ends of the upper pass-through range.
    task automatic test_byte_extremes();
        t_cfg c;
        c = '0;
        c.number_all_lines = 1'b1;
        c.show_nonprinting = 1'b1;
        c.show_line_ends   = 1'b1;
        c.show_tabs        = 1'b1;
        gap_max   = 0;
        stall_max = 0;
        apply_options(c);
        send_byte(8'h00);
        send_byte(8'h1F);
        send_byte(CH_TAB);
        send_byte(CH_SPACE);
        send_byte(8'h7E);
        send_byte(CH_DEL);
        send_byte(CH_META_LOW);
        send_byte(8'h9F);
        send_byte(CH_META_LIMIT);
        send_byte(8'hFF);
        send_byte(CH_NL);
    endtask

    // With squeezing off the run count stops at three. Turning squeezing on
    // in the middle of such a run drops the very next newline.
    task automatic test_run_count_saturated();
        t_cfg c;
        c = '0;
        gap_max   = 4;
        stall_max = 8;
        apply_options(c);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        send_byte(CH_NL);
        c.squeeze_blank_runs = 1'b1;
        apply_options(c);
        send_byte(CH_NL);
        send_byte("z");
    endtask

    // Eleven phases of random text. The first two use the all-off and all-on
    // settings, the rest random ones. The idling style rotates from phase to
    // phase, from none at all to long receiver stalls. Runs of newlines are
    // injected now and then so that squeezing gets real work.
    task automatic test_random_text();
        t_cfg c;
        int   ph;
        int   n;
        for (ph = 0; ph < 11; ph++) begin
            if (ph == 0) begin
                c = '0;
            end else if (ph == 1) begin
                c = '1;
            end else begin
                c = 6'($urandom_range(0, 63));
            end
            case (ph % 4)
                0: begin gap_max = 0;  stall_max = 0;  end
                1: begin gap_max = 3;  stall_max = 2;  end
                2: begin gap_max = 10; stall_max = 6;  end
                default: begin gap_max = 1; stall_max = 30; end
            endcase
            apply_options(c);
            n = 0;
            while (n < 30) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(2, 5)) begin
                        send_byte(CH_NL);
                        n++;
                    end
                end else begin
                    send_byte(text_byte());
                    n++;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stream_start_squeeze();
        test_byte_extremes();
        test_run_count_saturated();
        test_random_text();

        drain_and_settle();
        $display("Sent %0d input bytes under %0d option settings, checked %0d display bytes.",
                 bytes_sent, settings_used, bytes_checked);
        $display("Covered stream start, byte class edges, squeezing and numbering; %0d mismatches.",
                 errors);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/tdf_pkg.sv
sv/tdf_queue.sv
sv/tdf_front.sv
sv/tdf_back.sv
sv/text_display_filter.sv
tb/testbench.sv
